// ===== rtl/fgd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the fluxgate synchronous demodulator: field widths, default
// parameter values, configuration register indexes and the stage payload type.
// No dependencies.
package fgd_pkg;

  localparam int SAMPLE_W = 12;
  localparam int ACC_W    = 15;
  localparam int GSUM_W   = 26;
  localparam int OSR_W    = 10;
  localparam int LIMIT_W  = 12;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [OSR_W-1:0]   OSR_RESET   = 10'd47;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd1800;

  localparam int DRIVE_PERIODS_DEF = 10;
  localparam int KEPT_PERIODS_DEF  = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_OSR_RATIO = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_LIMIT = 1'd1;

  // One demodulated sample on its way from the accumulator stage to the
  // output stage.
  typedef struct packed {
    logic                     drive;
    logic                     done;
    logic signed [GSUM_W-1:0] total;
  } fgd_item_t;

endpackage

// ===== rtl/fgd_accum.sv =====
`timescale 1ns / 1ps
// Accumulator stage: sample position, pair accumulators, measurement count
// and group sum, registered into one stage item per accepted sample. Uses fgd_pkg.
module fgd_accum import fgd_pkg::*; #(
  parameter int DRIVE_PERIODS = DRIVE_PERIODS_DEF,
  parameter int KEPT_PERIODS  = KEPT_PERIODS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       take,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [OSR_W-1:0]           osr_ratio,
  output fgd_item_t                  item_r
);

  localparam int KEPT_EFF = (KEPT_PERIODS >= DRIVE_PERIODS) ? DRIVE_PERIODS : KEPT_PERIODS;
  localparam int CLEAR_AT = DRIVE_PERIODS - KEPT_EFF;
  localparam int LAST     = 2 * DRIVE_PERIODS - 1;
  localparam int POS_W    = $clog2(2 * DRIVE_PERIODS);
  localparam int DIFF_W   = ACC_W + 1;

  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic [OSR_W-1:0]         meas_r, meas_nxt;
  logic signed [ACC_W-1:0]  acc_first_r, acc_first_nxt;
  logic signed [ACC_W-1:0]  acc_second_r, acc_second_nxt;
  logic signed [GSUM_W-1:0] gsum_r, gsum_nxt;
  fgd_item_t                item_nxt;

  logic                     first_half;
  logic                     clear_acc;
  logic                     last_sample;
  logic [OSR_W-1:0]         osr_eff;
  logic [OSR_W-1:0]         meas_inc;
  logic signed [DIFF_W-1:0] diff;
  logic signed [GSUM_W-1:0] gsum_add;
  logic                     group_end;

  always_comb begin
    first_half  = ~pos_r[0];
    clear_acc   = first_half && ((pos_r[POS_W-1:1] == '0) ||
                  (pos_r[POS_W-1:1] == CLEAR_AT[POS_W-2:0]));
    last_sample = (pos_r == LAST[POS_W-1:0]);
    osr_eff     = (osr_ratio == '0) ? OSR_W'(1) : osr_ratio;

    acc_first_nxt  = acc_first_r;
    acc_second_nxt = acc_second_r;
    if (first_half) begin
      acc_first_nxt  = (clear_acc ? ACC_W'(0) : acc_first_r) + ACC_W'(sample);
      acc_second_nxt = clear_acc ? ACC_W'(0) : acc_second_r;
    end else begin
      acc_second_nxt = acc_second_r + ACC_W'(sample);
    end

    diff      = DIFF_W'(acc_first_r) - DIFF_W'(acc_second_nxt);
    gsum_add  = gsum_r + GSUM_W'(diff);
    meas_inc  = meas_r + OSR_W'(1);
    group_end = last_sample && ((meas_inc == '0) || (meas_inc >= osr_eff));

    pos_nxt  = last_sample ? '0 : pos_r + POS_W'(1);
    meas_nxt = meas_r;
    gsum_nxt = gsum_r;
    if (last_sample) begin
      meas_nxt = group_end ? '0 : meas_inc;
      gsum_nxt = group_end ? '0 : gsum_add;
    end

    item_nxt.drive = first_half;
    item_nxt.done  = group_end;
    item_nxt.total = group_end ? gsum_add : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      meas_r       <= '0;
      acc_first_r  <= '0;
      acc_second_r <= '0;
      gsum_r       <= '0;
    end else if (take) begin
      pos_r        <= pos_nxt;
      meas_r       <= meas_nxt;
      acc_first_r  <= acc_first_nxt;
      acc_second_r <= acc_second_nxt;
      gsum_r       <= gsum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== rtl/fgd_thresh.sv =====
`timescale 1ns / 1ps
// Saturation threshold register: (limit + 1) * kept pairs * ratio, recomputed
// every cycle from the configuration registers. Uses fgd_pkg.
module fgd_thresh import fgd_pkg::*; #(
  parameter int DRIVE_PERIODS = DRIVE_PERIODS_DEF,
  parameter int KEPT_PERIODS  = KEPT_PERIODS_DEF,
  parameter int THR_W         = 29
) (
  input  logic               clk,
  input  logic [OSR_W-1:0]   osr_ratio,
  input  logic [LIMIT_W-1:0] sat_limit,
  output logic [THR_W-1:0]   thr_r
);

  localparam int KEPT_EFF = (KEPT_PERIODS >= DRIVE_PERIODS) ? DRIVE_PERIODS : KEPT_PERIODS;
  localparam int PROD_W   = LIMIT_W + 1 + OSR_W;

  logic [LIMIT_W:0]       limit_p1;
  logic [OSR_W-1:0]       osr_eff;
  logic [PROD_W-1:0]      prod;
  logic [THR_W-1:0]       thr_nxt;

  always_comb begin
    limit_p1 = {1'b0, sat_limit} + (LIMIT_W + 1)'(1);
    osr_eff  = (osr_ratio == '0) ? OSR_W'(1) : osr_ratio;
    prod     = PROD_W'(limit_p1) * PROD_W'(osr_eff);
    // The kept pair count is a constant, so this is a shift-and-add.
    thr_nxt  = THR_W'(prod) * THR_W'(KEPT_EFF);
  end

  always_ff @(posedge clk) begin
    thr_r <= thr_nxt;
  end

endmodule

// ===== rtl/fgd_out_stage.sv =====
`timescale 1ns / 1ps
// Output stage: saturation compare on the group total and the result
// register with its valid/stall handshake. Uses fgd_pkg.
module fgd_out_stage import fgd_pkg::*; #(
  parameter int THR_W = 29
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  fgd_item_t                item,
  input  logic [THR_W-1:0]         thr,
  input  logic                     out_stall,
  output logic                     ready,
  output logic                     out_valid,
  output logic                     out_coil_drive,
  output logic                     out_group_done,
  output logic signed [GSUM_W-1:0] out_group_total,
  output logic                     out_sat_flag
);

  localparam int CMP_W = (THR_W > GSUM_W) ? THR_W : GSUM_W;

  logic              out_valid_r, out_valid_nxt;
  logic              drive_r, done_r, sat_r;
  logic signed [GSUM_W-1:0] total_r;
  logic [GSUM_W-1:0] mag;
  logic              sat_nxt;

  always_comb begin
    // The most negative total still has a magnitude that fits unsigned.
    mag     = item.total[GSUM_W-1] ? GSUM_W'(-item.total) : GSUM_W'(item.total);
    sat_nxt = item.done && (CMP_W'(mag) >= CMP_W'(thr));
    ready   = !out_valid_r || !out_stall;

    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive_r <= item.drive;
      done_r  <= item.done;
      total_r <= item.total;
      sat_r   <= sat_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_coil_drive  = drive_r;
  assign out_group_done  = done_r;
  assign out_group_total = total_r;
  assign out_sat_flag    = sat_r;

endmodule

// ===== rtl/fluxgate_sync_demodulator_unit.sv =====
`timescale 1ns / 1ps
// Top level of the fluxgate synchronous demodulator: configuration registers,
// stage control and the two pipeline stages. Uses fgd_pkg and all fgd_ modules.
//
//   Port group  Direction  Signals
//   in_         input      in_valid, in_stall (out), in_adc_sample
//   out_        output     out_valid, out_stall (in), coil_drive, group_done,
//                          group_total, sat_flag
//   cfg_        input      cfg_we, cfg_index, cfg_data
//
// A sample is accepted every cycle while in_stall is low; each gives one result,
// registered in the accumulator stage with its adds and count compare, then in
// the output stage with the saturation compare.
// Reset is synchronous and active low; it restores the register defaults and
// clears position, count and sums. No clearing pass is needed.
// A stalled output holds its transaction; the accumulator stage still takes
// one more sample, after which in_stall follows out_stall.
module fluxgate_sync_demodulator_unit import fgd_pkg::*; #(
  parameter int DRIVE_PERIODS = DRIVE_PERIODS_DEF,
  parameter int KEPT_PERIODS  = KEPT_PERIODS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_adc_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_coil_drive,
  output logic                       out_group_done,
  output logic signed [GSUM_W-1:0]   out_group_total,
  output logic                       out_sat_flag,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam int KEPT_EFF = (KEPT_PERIODS >= DRIVE_PERIODS) ? DRIVE_PERIODS : KEPT_PERIODS;
  localparam int THR_W    = LIMIT_W + 1 + OSR_W + $clog2(KEPT_EFF + 1);

  logic [OSR_W-1:0]   osr_ratio_r;
  logic [LIMIT_W-1:0] sat_limit_r;
  logic               s1_valid_r, s1_valid_nxt;
  logic               accept;
  logic               out_ready;
  logic               s1_adv;
  fgd_item_t          s1_item;
  logic [THR_W-1:0]   thr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      osr_ratio_r <= OSR_RESET;
      sat_limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OSR_RATIO: osr_ratio_r <= cfg_data[OSR_W-1:0];
        CFG_SAT_LIMIT: sat_limit_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_adv   = s1_valid_r && out_ready;
    in_stall = s1_valid_r && !out_ready;
    accept   = in_valid && !in_stall;

    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  fgd_accum #(
    .DRIVE_PERIODS(DRIVE_PERIODS),
    .KEPT_PERIODS (KEPT_PERIODS)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (accept),
    .sample   (in_adc_sample),
    .osr_ratio(osr_ratio_r),
    .item_r   (s1_item)
  );

  fgd_thresh #(
    .DRIVE_PERIODS(DRIVE_PERIODS),
    .KEPT_PERIODS (KEPT_PERIODS),
    .THR_W        (THR_W)
  ) u_thresh (
    .clk      (clk),
    .osr_ratio(osr_ratio_r),
    .sat_limit(sat_limit_r),
    .thr_r    (thr)
  );

  fgd_out_stage #(
    .THR_W(THR_W)
  ) u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (s1_adv),
    .item           (s1_item),
    .thr            (thr),
    .out_stall      (out_stall),
    .ready          (out_ready),
    .out_valid      (out_valid),
    .out_coil_drive (out_coil_drive),
    .out_group_done (out_group_done),
    .out_group_total(out_group_total),
    .out_sat_flag   (out_sat_flag)
  );

  // A result that does not close a group carries no total and no flag.
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_group_done) |-> (out_group_total == '0 && !out_sat_flag))
    else $error("non-final result carries group data");

  // The input is held off only while both stages hold a transaction.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid))
    else $error("input stalled with a free stage");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

// ===== bench/fluxgate_sync_demodulator_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for fluxgate_sync_demodulator_unit: streams converter samples
// over the valid/stall channels and compares every result transaction with a predictor.
// Depends on fgd_pkg and the unit's RTL; nothing else.
module fluxgate_sync_demodulator_unit_tb;
  import fgd_pkg::*;

  localparam int KEPT_PAIRS   = (KEPT_PERIODS_DEF >= DRIVE_PERIODS_DEF) ?
                                DRIVE_PERIODS_DEF : KEPT_PERIODS_DEF;
  localparam int CLEAR_PERIOD = DRIVE_PERIODS_DEF - KEPT_PAIRS;
  localparam int MEAS_SAMPLES = 2 * DRIVE_PERIODS_DEF;
  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 500;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic                     drive;
    logic                     done;
    logic signed [GSUM_W-1:0] total;
    logic                     sat;
  } demod_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  sample_t                  in_adc_sample;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_coil_drive;
  logic                     out_group_done;
  logic signed [GSUM_W-1:0] out_group_total;
  logic                     out_sat_flag;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]         cfg_data;

  // Predictor copy of the registers and of the demodulator state.
  logic [OSR_W-1:0]         osr_setting;
  logic [LIMIT_W-1:0]       limit_setting;
  int unsigned              half_pos;
  logic [OSR_W-1:0]         meas_done;
  logic signed [ACC_W-1:0]  acc_high;
  logic signed [ACC_W-1:0]  acc_low;
  logic signed [GSUM_W-1:0] group_acc;

  demod_result_t pending_results[$];
  int errors;
  int idle_cycles = 0;
  int burst_left;
  int stall_left = 0;
  bit gaps_on;

  fluxgate_sync_demodulator_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_adc_sample   (in_adc_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_coil_drive  (out_coil_drive),
    .out_group_done  (out_group_done),
    .out_group_total (out_group_total),
    .out_sat_flag    (out_sat_flag),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic demod_result_t demodulate(input sample_t s);
    int unsigned   cur;
    longint        osr_eff;
    longint        total;
    longint        mag;
    longint        threshold;
    demod_result_t r;
    r = '0;
    cur = (half_pos >= MEAS_SAMPLES) ? 0 : half_pos;
    if (cur % 2 == 0) begin
      // Both accumulators restart at the first period and again where the kept
      // periods begin, so only the tail of the measurement counts.
      if (cur / 2 == 0 || cur / 2 == CLEAR_PERIOD) begin
        acc_high = '0;
        acc_low  = '0;
      end
      acc_high = acc_high + s;
      r.drive  = 1'b1;
    end else begin
      acc_low = acc_low + s;
    end
    if (cur == MEAS_SAMPLES - 1) begin
      osr_eff   = (osr_setting == 0) ? 1 : osr_setting;
      group_acc = group_acc + (acc_high - acc_low);
      meas_done = meas_done + 1'b1;
      half_pos  = 0;
      if (meas_done == 0 || meas_done >= osr_eff) begin
        total     = group_acc;
        mag       = (total < 0) ? -total : total;
        threshold = (longint'(limit_setting) + 1) * KEPT_PAIRS * osr_eff;
        r.done    = 1'b1;
        r.total   = group_acc;
        r.sat     = (mag >= threshold);
        group_acc = '0;
        meas_done = '0;
      end
    end else begin
      half_pos = cur + 1;
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    demod_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        pending_results.push_back(demodulate(in_adc_sample));
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          errors++;
          $error("result transaction with no sample pending");
        end else begin
          want = pending_results.pop_front();
          if (out_coil_drive !== want.drive) begin
            errors++;
            $error("coil_drive: expected %0d, got %0d", want.drive, out_coil_drive);
          end
          if (out_group_done !== want.done) begin
            errors++;
            $error("group_done: expected %0d, got %0d", want.done, out_group_done);
          end
          if (out_group_total !== want.total) begin
            errors++;
            $error("group_total: expected %0d, got %0d", want.total, out_group_total);
          end
          if (out_sat_flag !== want.sat) begin
            errors++;
            $error("sat_flag: expected %0d, got %0d", want.sat, out_sat_flag);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("fluxgate_sync_demodulator_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: long quiet stretches mixed with short runs of random stalls.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(20, 120);
      end else begin
        out_stall  <= $urandom_range(0, 1);
        stall_left <= $urandom_range(1, 6);
      end
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Returns right after the accepting edge so the next call can keep valid high.
  task automatic send_sample(input sample_t s);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_adc_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_OSR_RATIO)
      osr_setting = value[OSR_W-1:0];
    else
      limit_setting = value[LIMIT_W-1:0];
  endtask

  task automatic send_pairs(input sample_t first, input sample_t second, input int n);
    for (int i = 0; i < n; i++) begin
      send_sample(first);
      send_sample(second);
    end
  endtask

  // Alternating +amp/-amp with noise, or full-range samples when wild is set.
  task automatic send_shaped(input int n, input int amp, input int noise, input bit wild);
    int v;
    for (int i = 0; i < n; i++) begin
      if (wild) begin
        v = sample_t'($urandom_range(0, 4095));
      end else begin
        v = ((i % 2 == 0) ? amp : -amp) + int'($urandom_range(0, 2 * noise)) - noise;
        if (v > 2047)
          v = 2047;
        else if (v < -2048)
          v = -2048;
      end
      send_sample(sample_t'(v));
    end
  endtask

  task automatic test_reset_defaults();
    gaps_on = 1'b1;
    send_shaped(47 * MEAS_SAMPLES + 60, 900, 30, 1'b0);
  endtask

  // Full-scale pairs; discarded early periods carry the opposite sign first, zeros next.
  task automatic test_drive_extremes();
    write_reg(CFG_OSR_RATIO, 0);
    write_reg(CFG_SAT_LIMIT, 4095);
    send_pairs(-12'sd2048, 12'sd2047, CLEAR_PERIOD);
    send_pairs(12'sd2047, -12'sd2048, KEPT_PAIRS);
    write_reg(CFG_SAT_LIMIT, 4094);
    send_pairs(12'sd0, 12'sd0, CLEAR_PERIOD);
    send_pairs(-12'sd2048, 12'sd2047, KEPT_PAIRS);
  endtask

  task automatic test_limit_boundary();
    write_reg(CFG_SAT_LIMIT, 0);
    write_reg(CFG_OSR_RATIO, 1);
    send_pairs(12'sd0, 12'sd0, DRIVE_PERIODS_DEF);
    send_pairs(12'sd0, 12'sd0, DRIVE_PERIODS_DEF - 1);
    send_pairs(12'sd1, 12'sd0, 1);
    send_pairs(12'sd1, 12'sd0, DRIVE_PERIODS_DEF);
  endtask

  // The group closes on the first measurement after the ratio drops below the count.
  task automatic test_ratio_lowered();
    write_reg(CFG_OSR_RATIO, 5);
    write_reg(CFG_SAT_LIMIT, 300);
    send_shaped(3 * MEAS_SAMPLES, 150, 20, 1'b0);
    write_reg(CFG_OSR_RATIO, 2);
    send_shaped(MEAS_SAMPLES, 150, 20, 1'b0);
  endtask

  task automatic test_random_settings();
    int sent;
    int ratio;
    int limit_pick;
    int amp;
    int n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      limit_pick = $urandom_range(0, 9);
      ratio = (limit_pick == 0) ? 0 :
              (limit_pick < 8) ? $urandom_range(1, 4) : $urandom_range(5, 24);
      write_reg(CFG_OSR_RATIO, ratio);
      limit_pick = $urandom_range(0, 5);
      write_reg(CFG_SAT_LIMIT, (limit_pick == 0) ? 0 :
                               (limit_pick == 1) ? 4095 : $urandom_range(0, 4095));
      gaps_on = ($urandom_range(0, 3) != 0);
      // Aim the pair difference at the limit so the flag falls on both sides.
      amp = int'(limit_setting) / 2 + int'($urandom_range(0, 8)) - 4;
      if ($urandom_range(0, 1))
        amp = -amp;
      n = ((ratio == 0) ? 1 : ratio) * MEAS_SAMPLES * $urandom_range(2, 4);
      send_shaped(n, amp, $urandom_range(0, 40), $urandom_range(0, 4) == 0);
      sent += n;
    end
  endtask

  // Full-scale measurements pile up under the largest ratio, then a lower ratio
  // closes the group with a saturated total.
  task automatic test_max_ratio();
    gaps_on = 1'b0;
    write_reg(CFG_OSR_RATIO, 1023);
    write_reg(CFG_SAT_LIMIT, 4095);
    send_pairs(12'sd2047, -12'sd2048, DRIVE_PERIODS_DEF * 10);
    write_reg(CFG_OSR_RATIO, 10);
    send_pairs(12'sd2047, -12'sd2048, DRIVE_PERIODS_DEF);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_adc_sample = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_OSR_RATIO;
    cfg_data      = '0;
    osr_setting   = OSR_RESET;
    limit_setting = LIMIT_RESET;
    half_pos      = 0;
    meas_done     = '0;
    acc_high      = '0;
    acc_low       = '0;
    group_acc     = '0;
    errors        = 0;
    burst_left    = 0;
    gaps_on       = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_drive_extremes();
    test_limit_boundary();
    test_ratio_lowered();
    test_random_settings();
    test_max_ratio();

    settle();
    repeat (8) @(negedge clk);
    if (errors == 0)
      $display("fluxgate_sync_demodulator_unit verification clean");
    else
      $display("fluxgate_sync_demodulator_unit verification failed");
    $finish;
  end

endmodule

// ===== fluxgate_sync_demodulator_unit.f =====
rtl/fgd_pkg.sv
rtl/fgd_accum.sv
rtl/fgd_thresh.sv
rtl/fgd_out_stage.sv
rtl/fluxgate_sync_demodulator_unit.sv
bench/fluxgate_sync_demodulator_unit_tb.sv
